[src/fcc_pkg.sv]
// Shared types, codes and handshake structs for the four-function calculator core.
`default_nettype none

package fcc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KeyW   = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 5;

  // Key kinds as they arrive on the op field
  typedef enum logic [KeyW-1:0] {
    KEY_DIGIT  = 4'd0,
    KEY_CLEAR  = 4'd1,
    KEY_NEGATE = 4'd2,
    KEY_EQUALS = 4'd3,
    KEY_ADD    = 4'd4,
    KEY_SUB    = 4'd5,
    KEY_MUL    = 4'd6,
    KEY_DIV    = 4'd7,
    KEY_MOD    = 4'd8
  } key_op_t;

  // Pending operator codes held between operands
  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_ADD  = 3'd1,
    PEND_SUB  = 3'd2,
    PEND_MUL  = 3'd3,
    PEND_DIV  = 3'd4,
    PEND_MOD  = 3'd5
  } pend_op_t;

  localparam logic [3:0] MaxDigit = 4'd9;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_key;
    logic start_div;
    logic step_div;
    logic update;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_mul;
    logic needs_div;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[src/fcc_ctrl.sv]
// Controller state machine: sequences key capture, long operations and result hand-off.
`default_nettype none

module fcc_ctrl
  import fcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.needs_mul) begin
          state_next = ST_MUL;
        end else if (status.needs_div) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL:    state_next = ST_COMMIT;
      ST_DIV: begin
        if (status.div_last) state_next = ST_COMMIT;
      end
      ST_COMMIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_key = in_valid;
      end
      ST_EXEC: begin
        cmd.start_div = status.needs_div && !status.needs_mul;
        cmd.update    = !status.needs_mul && !status.needs_div;
      end
      ST_MUL: ;
      ST_DIV: begin
        cmd.step_div = 1'b1;
      end
      ST_COMMIT: begin
        cmd.update = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/fcc_datapath.sv]
// Datapath: calculator state, multiplier, one-bit-per-cycle divider and output register.
`default_nettype none

module fcc_datapath
  import fcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [KeyW-1:0]          op,
  input  wire logic [DigitW-1:0]        digit,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DataW-1:0]       display_value,
  output logic                          operator_pending
);

  // Calculator state
  logic [DataW-1:0]  accumulator;
  logic [DataW-1:0]  entry_operand;
  pend_op_t          pending_operator;
  logic              pending_valid;
  logic              fresh_entry;
  logic [DataW-1:0]  shown_value;

  // Captured request
  logic [KeyW-1:0]   key_op;
  logic [DigitW-1:0] key_digit;

  // Long-operation registers
  logic [DataW-1:0]  product;
  logic [DataW-1:0]  quo;
  logic [DataW-1:0]  rem;
  logic [DataW-1:0]  divisor;
  logic [CountW-1:0] div_count;

  logic              acc_neg;
  logic              opd_neg;
  logic [DataW-1:0]  acc_mag;
  logic [DataW-1:0]  opd_mag;
  logic              is_operator;
  logic              applies;
  logic [DataW-1:0]  arith_res;
  logic [DataW-1:0]  entry_base;
  logic [DataW-1:0]  digit_res;
  logic [DataW:0]    shifted;
  logic [DataW:0]    trial;
  logic [2:0]        key_pend;

  assign acc_neg = accumulator[DataW-1];
  assign opd_neg = entry_operand[DataW-1];
  assign acc_mag = acc_neg ? (DataW'(0) - accumulator) : accumulator;
  assign opd_mag = opd_neg ? (DataW'(0) - entry_operand) : entry_operand;

  // Key classification
  assign is_operator = (key_op >= KEY_ADD) && (key_op <= KEY_MOD);
  assign applies     = pending_valid && ((key_op == KEY_EQUALS) || is_operator);
  assign key_pend    = 3'(key_op - KEY_EQUALS);

  assign status.needs_mul = applies && (pending_operator == PEND_MUL);
  assign status.needs_div = applies && (opd_mag != '0) &&
                            ((pending_operator == PEND_DIV) || (pending_operator == PEND_MOD));
  assign status.div_last  = (div_count == {CountW{1'b1}});
  assign status.out_busy  = out_valid && !out_ready;

  // Result of the pending operation; a zero divisor keeps the accumulator
  always_comb begin
    case (pending_operator)
      PEND_ADD: arith_res = accumulator + entry_operand;
      PEND_SUB: arith_res = accumulator - entry_operand;
      PEND_MUL: arith_res = product;
      PEND_DIV: begin
        if (opd_mag == '0) begin
          arith_res = accumulator;
        end else begin
          arith_res = (acc_neg != opd_neg) ? (DataW'(0) - quo) : quo;
        end
      end
      PEND_MOD: begin
        if (opd_mag == '0) begin
          arith_res = accumulator;
        end else begin
          arith_res = acc_neg ? (DataW'(0) - rem) : rem;
        end
      end
      default:  arith_res = accumulator;
    endcase
  end

  // Digit entry: operand * 10 + digit, wrapping
  assign entry_base = fresh_entry ? '0 : entry_operand;
  assign digit_res  = (entry_base << 3) + (entry_base << 1) + DataW'(key_digit);

  // Restoring divider step
  assign shifted = {rem, quo[DataW-1]};
  assign trial   = shifted - {1'b0, divisor};

  // Request capture, multiplier and divider
  always_ff @(posedge clk) begin
    product <= accumulator * entry_operand;
    if (cmd.load_key) begin
      key_op    <= op;
      key_digit <= digit;
    end
    if (cmd.start_div) begin
      quo       <= acc_mag;
      rem       <= '0;
      divisor   <= opd_mag;
      div_count <= '0;
    end else if (cmd.step_div) begin
      div_count <= div_count + CountW'(1);
      if (!trial[DataW]) begin
        rem <= trial[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b1};
      end else begin
        rem <= shifted[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b0};
      end
    end
  end

  // Calculator state update
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator      <= '0;
      entry_operand    <= '0;
      pending_operator <= PEND_NONE;
      pending_valid    <= 1'b0;
      fresh_entry      <= 1'b1;
      shown_value      <= '0;
    end else if (cmd.update) begin
      case (key_op)
        KEY_DIGIT: begin
          if (key_digit <= MaxDigit) begin
            entry_operand <= digit_res;
            shown_value   <= digit_res;
            fresh_entry   <= 1'b0;
          end
        end
        KEY_CLEAR: begin
          accumulator      <= '0;
          entry_operand    <= '0;
          pending_operator <= PEND_NONE;
          pending_valid    <= 1'b0;
          fresh_entry      <= 1'b1;
          shown_value      <= '0;
        end
        KEY_NEGATE: begin
          entry_operand <= DataW'(0) - entry_operand;
          shown_value   <= DataW'(0) - entry_operand;
        end
        KEY_EQUALS: begin
          if (pending_valid) begin
            accumulator   <= arith_res;
            shown_value   <= arith_res;
            entry_operand <= arith_res;
            pending_valid <= 1'b0;
            fresh_entry   <= 1'b1;
          end
        end
        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_MOD: begin
          if (pending_valid) begin
            accumulator <= arith_res;
            shown_value <= arith_res;
          end else begin
            accumulator <= entry_operand;
          end
          pending_operator <= pend_op_t'(key_pend);
          pending_valid    <= 1'b1;
          fresh_entry      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      display_value    <= shown_value;
      operator_pending <= pending_valid;
    end
  end

endmodule

`default_nettype wire

[src/four_function_calculator_core_top.sv]
// Top level of the four-function integer calculator core.
`default_nettype none

// Takes one keypress request at a time and returns one result per key: the
// value on the display and whether an operator awaits its second operand.
// A key is captured, executed and its result loaded into the output register.
// Applying a pending multiply adds one registered 32x32 multiply; applying a
// pending divide or remainder with a nonzero divisor adds the restoring
// divider, which retires one quotient bit per cycle until all 32 are done.
// Keys are handled one at a time; the next key is taken as soon as the result
// is in the output register, even while that result still waits to be taken.
module four_function_calculator_core_top
  import fcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KeyW-1:0]      op,
  input  wire logic [DigitW-1:0]    digit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DataW-1:0]   display_value,
  output logic                      operator_pending
);

  cmd_t    cmd;
  status_t status;

  fcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fcc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .digit            (digit),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .display_value    (display_value),
    .operator_pending (operator_pending)
  );

endmodule

`default_nettype wire
